// File: hw/rtl/dtft_pkg.sv
// ----------------------------------------------------------------------------
// dtft_pkg: shared types and constants of the text field tokenizer
// Byte codes, byte classes, result status codes and the front-to-back token.
// ----------------------------------------------------------------------------
package dtft_pkg;

  localparam int unsigned OffsetBits = 32;
  localparam int unsigned RowBits    = 16;
  localparam int unsigned ColBits    = 10;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned FieldRowW  = 16;
  localparam int unsigned FieldColW  = 10;
  localparam int unsigned FieldOffW  = 32;

  localparam logic [ByteW-1:0] ChSp    = 8'd32;
  localparam logic [ByteW-1:0] ChTab   = 8'd9;
  localparam logic [ByteW-1:0] ChLf    = 8'd10;
  localparam logic [ByteW-1:0] ChCr    = 8'd13;
  localparam logic [ByteW-1:0] ChComma = 8'd44;
  localparam logic [ByteW-1:0] ChQuote = 8'd34;

  typedef enum logic [2:0] {
    ClsEot,
    ClsSp,
    ClsTab,
    ClsLf,
    ClsCr,
    ClsComma,
    ClsQuote,
    ClsOther
  } cls_e;

  typedef enum logic [StatusW-1:0] {
    StField     = 2'd0,
    StOpenQuote = 2'd1,
    StBadChar   = 2'd2
  } status_e;

  typedef struct packed {
    logic valid;
    cls_e cls;
  } tok_t;

endpackage

// File: hw/rtl/dtft_if.sv
// ----------------------------------------------------------------------------
// dtft_if: channel interfaces of the text field tokenizer
// Byte input channel, field result channel and format register write channel.
// ----------------------------------------------------------------------------
interface dtft_in_if;
  logic                       valid;
  logic                       ready;
  logic [dtft_pkg::ByteW-1:0] data_byte;
  logic                       end_of_text;

  modport source (output valid, data_byte, end_of_text, input ready);
  modport sink   (input valid, data_byte, end_of_text, output ready);
endinterface

interface dtft_out_if;
  logic                           valid;
  logic                           ready;
  logic [dtft_pkg::StatusW-1:0]   status;
  logic [dtft_pkg::FieldRowW-1:0] row_index;
  logic [dtft_pkg::FieldColW-1:0] column_index;
  logic [dtft_pkg::FieldOffW-1:0] field_start;
  logic [dtft_pkg::FieldOffW-1:0] field_end;
  logic                           last_in_row;

  modport source (output valid, status, row_index, column_index, field_start, field_end,
                  last_in_row, input ready);
  modport sink   (input valid, status, row_index, column_index, field_start, field_end,
                  last_in_row, output ready);
endinterface

interface dtft_cfg_if;
  logic valid;
  logic ready;
  logic format_mode;

  modport source (output valid, format_mode, input ready);
  modport sink   (input valid, format_mode, output ready);
endinterface

// File: hw/rtl/dtft_front.sv
// ----------------------------------------------------------------------------
// dtft_front: byte intake and classification
// Accepts bytes, reduces each to a byte class and queues it for the back end
// in a two-entry queue.
// ----------------------------------------------------------------------------
module dtft_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  dtft_in_if.sink        in_i,
  input  logic           pop_i,
  output dtft_pkg::tok_t tok_o
);
  import dtft_pkg::*;

  cls_e       cls_in;
  cls_e       ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  always_comb begin
    if (in_i.end_of_text || in_i.data_byte == '0) begin
      cls_in = ClsEot;
    end else begin
      case (in_i.data_byte)
        ChSp:    cls_in = ClsSp;
        ChTab:   cls_in = ClsTab;
        ChLf:    cls_in = ClsLf;
        ChCr:    cls_in = ClsCr;
        ChComma: cls_in = ClsComma;
        ChQuote: cls_in = ClsQuote;
        default: cls_in = ClsOther;
      endcase
    end
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    wr_d  = push  ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cls_in;
    end
  end

  assign tok_o.valid = (cnt_q != 2'd0);
  assign tok_o.cls   = ent_q[rd_q];

endmodule

// File: hw/rtl/dtft_back.sv
// ----------------------------------------------------------------------------
// dtft_back: field parser
// Runs the per-byte parse state machine on queued byte classes, tracks
// offsets, row and column, and holds the result in an output register.
// ----------------------------------------------------------------------------
module dtft_back #(
  parameter int unsigned OffsetBits = dtft_pkg::OffsetBits,
  parameter int unsigned RowBits    = dtft_pkg::RowBits,
  parameter int unsigned ColBits    = dtft_pkg::ColBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fmt_i,
  input  dtft_pkg::tok_t tok_i,
  output logic           pop_o,
  dtft_out_if.source     out_o
);
  import dtft_pkg::*;

  localparam int unsigned EndW = OffsetBits + 1;

  typedef enum logic [2:0] {
    PhRow,
    PhPre,
    PhBare,
    PhQuoted,
    PhAfterQ,
    PhError,
    PhTab
  } phase_e;

  phase_e                phase_q, phase_d, ph_x;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [RowBits-1:0]    row_q, row_d;
  logic [ColBits-1:0]    col_q, col_d;
  logic [OffsetBits-1:0] cs_q, cs_d;
  logic [EndW-1:0]       ce_q, ce_d;
  logic [OffsetBits-1:0] is_q, is_d;
  logic [EndW-1:0]       ie_q, ie_d;
  logic [1:0]            qf_q, qf_d, qf_x;
  logic [1:0]            ns_q, ns_d, ns_x;
  logic                  lfs_q, lfs_d;

  logic                  out_vld_q, out_vld_d;
  status_e               out_st_q, out_st_d;
  logic [FieldRowW-1:0]  out_row_q, out_row_d;
  logic [FieldColW-1:0]  out_col_q, out_col_d;
  logic [FieldOffW-1:0]  out_s_q, out_s_d;
  logic [FieldOffW-1:0]  out_e_q, out_e_d;
  logic                  out_last_q, out_last_d;

  logic                  emit, em_last, skip, blank, brk, isq, eot;
  status_e               em_st;
  logic [EndW-1:0]       em_s, em_e, pe, p1, is_e, tab_s, tab_e;
  logic [RowBits+FieldRowW-1:0] row_w;
  logic [ColBits+FieldColW-1:0] col_w;
  logic [EndW+FieldOffW-1:0]    s_w, e_w;

  assign pop_o = tok_i.valid && (!out_vld_q || out_o.ready);

  assign pe    = {1'b0, pos_q};
  assign p1    = pe + {{(EndW-1){1'b0}}, 1'b1};
  assign is_e  = {1'b0, is_q};
  assign eot   = (tok_i.cls == ClsEot);
  assign blank = (tok_i.cls == ClsSp) || (tok_i.cls == ClsTab);
  assign brk   = (tok_i.cls == ClsLf) || (tok_i.cls == ClsCr);
  assign isq   = (tok_i.cls == ClsQuote);

  always_comb begin
    ph_x = phase_q;
    ns_x = ns_q;
    qf_x = qf_q;
    skip = 1'b0;
    if (!eot && phase_q == PhRow) begin
      if (lfs_q && tok_i.cls == ClsLf) begin
        skip = 1'b1;
      end else if (fmt_i) begin
        ph_x = PhTab;
        ns_x = 2'd0;
        qf_x = 2'd0;
      end else begin
        ph_x = PhPre;
      end
    end
  end

  always_comb begin
    if (ns_x == 2'd0) begin
      tab_s = pe;
      tab_e = pe;
    end else if (ns_x == 2'd2 && qf_x == 2'b11) begin
      tab_s = is_e;
      tab_e = (ie_q > is_e) ? ie_q : is_e;
    end else begin
      tab_s = {1'b0, cs_q};
      tab_e = ce_q;
    end
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    row_d   = row_q;
    col_d   = col_q;
    cs_d    = cs_q;
    ce_d    = ce_q;
    is_d    = is_q;
    ie_d    = ie_q;
    qf_d    = qf_q;
    ns_d    = ns_q;
    lfs_d   = lfs_q;
    emit    = 1'b0;
    em_st   = StField;
    em_s    = '0;
    em_e    = '0;
    em_last = 1'b0;

    if (eot) begin
      case (phase_q)
        PhPre: begin
          emit = 1'b1; em_s = pe; em_e = pe; em_last = 1'b1;
        end
        PhBare, PhAfterQ: begin
          emit = 1'b1; em_s = {1'b0, cs_q}; em_e = ce_q; em_last = 1'b1;
        end
        PhQuoted: begin
          emit = 1'b1; em_st = StOpenQuote; em_s = pe; em_e = pe;
        end
        PhTab: begin
          emit = 1'b1; em_s = tab_s; em_e = tab_e; em_last = 1'b1;
        end
        default: ;
      endcase
    end else begin
      if (pos_q != '1) begin
        pos_d = pos_q + {{(OffsetBits-1){1'b0}}, 1'b1};
      end
      if (phase_q == PhRow) begin
        lfs_d = 1'b0;
      end
      phase_d = ph_x;
      ns_d    = ns_x;
      qf_d    = qf_x;
      if (!skip) begin
        case (ph_x)
          PhPre: begin
            if (blank) begin
            end else if (isq) begin
              phase_d = PhQuoted;
              ns_d    = 2'd0;
            end else if (tok_i.cls == ClsComma) begin
              emit = 1'b1; em_s = pe; em_e = pe;
            end else if (brk) begin
              emit = 1'b1; em_s = pe; em_e = pe; em_last = 1'b1;
              phase_d = PhRow;
              lfs_d   = (tok_i.cls == ClsCr);
            end else begin
              phase_d = PhBare;
              cs_d    = pos_q;
              ce_d    = p1;
            end
          end
          PhBare: begin
            if (tok_i.cls == ClsComma) begin
              emit = 1'b1; em_s = {1'b0, cs_q}; em_e = ce_q;
              phase_d = PhPre;
            end else if (brk) begin
              emit = 1'b1; em_s = {1'b0, cs_q}; em_e = ce_q; em_last = 1'b1;
              phase_d = PhRow;
              lfs_d   = (tok_i.cls == ClsCr);
            end else if (!blank) begin
              ce_d = p1;
            end
          end
          PhQuoted: begin
            if (isq) begin
              if (ns_x == 2'd0) begin
                cs_d = pos_q;
                ce_d = pe;
              end
              phase_d = PhAfterQ;
            end else if (!blank) begin
              if (ns_x == 2'd0) begin
                cs_d = pos_q;
                ns_d = 2'd1;
              end
              ce_d = p1;
            end
          end
          PhAfterQ: begin
            if (blank) begin
            end else if (tok_i.cls == ClsComma) begin
              emit = 1'b1; em_s = {1'b0, cs_q}; em_e = ce_q;
              phase_d = PhPre;
            end else if (brk) begin
              emit = 1'b1; em_s = {1'b0, cs_q}; em_e = ce_q; em_last = 1'b1;
              phase_d = PhRow;
              lfs_d   = (tok_i.cls == ClsCr);
            end else begin
              emit = 1'b1; em_st = StBadChar; em_s = pe; em_e = pe;
              phase_d = PhError;
            end
          end
          PhTab: begin
            if (tok_i.cls == ClsTab) begin
              emit = 1'b1; em_s = tab_s; em_e = tab_e;
              ns_d = 2'd0;
              qf_d = 2'd0;
            end else if (brk) begin
              emit = 1'b1; em_s = tab_s; em_e = tab_e; em_last = 1'b1;
              ns_d    = 2'd0;
              qf_d    = 2'd0;
              phase_d = PhRow;
              lfs_d   = (tok_i.cls == ClsCr);
            end else if (tok_i.cls != ClsSp) begin
              if (ns_x == 2'd0) begin
                cs_d = pos_q;
                qf_d = {isq, isq};
              end else begin
                if (ns_x == 2'd1) begin
                  is_d = pos_q;
                end
                ie_d = ce_q;
                qf_d = {isq, qf_x[0]};
              end
              ce_d = p1;
              if (ns_x != 2'd2) begin
                ns_d = ns_x + 2'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end

    // advance row and column past a reported field
    if (emit && em_st == StField) begin
      if (em_last) begin
        if (row_q != '1) begin
          row_d = row_q + {{(RowBits-1){1'b0}}, 1'b1};
        end
        col_d = '0;
      end else if (col_q != '1) begin
        col_d = col_q + {{(ColBits-1){1'b0}}, 1'b1};
      end
    end

    if (eot) begin
      phase_d = PhRow;
      pos_d   = '0;
      row_d   = '0;
      col_d   = '0;
      cs_d    = '0;
      ce_d    = '0;
      is_d    = '0;
      ie_d    = '0;
      qf_d    = '0;
      ns_d    = '0;
      lfs_d   = 1'b0;
    end
  end

  assign row_w = {{FieldRowW{1'b0}}, row_q};
  assign col_w = {{FieldColW{1'b0}}, col_q};
  assign s_w   = {{FieldOffW{1'b0}}, em_s};
  assign e_w   = {{FieldOffW{1'b0}}, em_e};

  always_comb begin
    out_vld_d  = out_vld_q;
    out_st_d   = out_st_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_s_d    = out_s_q;
    out_e_d    = out_e_q;
    out_last_d = out_last_q;
    if (pop_o) begin
      out_vld_d = emit;
      if (emit) begin
        out_st_d   = em_st;
        out_row_d  = row_w[FieldRowW-1:0];
        out_col_d  = col_w[FieldColW-1:0];
        out_s_d    = s_w[FieldOffW-1:0];
        out_e_d    = e_w[FieldOffW-1:0];
        out_last_d = em_last;
      end
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhRow;
      pos_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      cs_q       <= '0;
      ce_q       <= '0;
      is_q       <= '0;
      ie_q       <= '0;
      qf_q       <= '0;
      ns_q       <= '0;
      lfs_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      out_st_q   <= StField;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_s_q    <= '0;
      out_e_q    <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        row_q   <= row_d;
        col_q   <= col_d;
        cs_q    <= cs_d;
        ce_q    <= ce_d;
        is_q    <= is_d;
        ie_q    <= ie_d;
        qf_q    <= qf_d;
        ns_q    <= ns_d;
        lfs_q   <= lfs_d;
      end
      out_vld_q  <= out_vld_d;
      out_st_q   <= out_st_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_s_q    <= out_s_d;
      out_e_q    <= out_e_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_st_q;
  assign out_o.row_index    = out_row_q;
  assign out_o.column_index = out_col_q;
  assign out_o.field_start  = out_s_q;
  assign out_o.field_end    = out_e_q;
  assign out_o.last_in_row  = out_last_q;

endmodule

// File: hw/rtl/delimited_text_field_tokenizer.sv
// ----------------------------------------------------------------------------
// delimited_text_field_tokenizer: CSV and tab-delimited field tokenizer
// Takes text one byte per item and reports each field's row, column and
// content span, with quote errors, through a queued front and parse back end.
// ----------------------------------------------------------------------------
// Path: each accepted byte is queued, then parsed into the registered result.
// Throughput: one byte per cycle while no held output result stalls the parser.
// Queue: two byte classes between intake and parser absorb output stalls.
// Reset: row start, all offsets and counters zero, comma mode selected.
// ----------------------------------------------------------------------------
module delimited_text_field_tokenizer #(
  parameter int unsigned OFFSET_BITS = dtft_pkg::OffsetBits,
  parameter int unsigned ROW_BITS    = dtft_pkg::RowBits,
  parameter int unsigned COL_BITS    = dtft_pkg::ColBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtft_in_if.sink    in_i,
  dtft_out_if.source out_o,
  dtft_cfg_if.sink   cfg_i
);
  import dtft_pkg::*;

  logic fmt_q;
  logic pop;
  tok_t tok;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      fmt_q <= cfg_i.format_mode;
    end
  end

  dtft_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .tok_o  (tok)
  );

  dtft_back #(
    .OffsetBits (OFFSET_BITS),
    .RowBits    (ROW_BITS),
    .ColBits    (COL_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fmt_i  (fmt_q),
    .tok_i  (tok),
    .pop_o  (pop),
    .out_o  (out_o)
  );

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != StField |->
      !out_o.last_in_row && out_o.field_start == out_o.field_end)
    else $error("error result carries a field span or row end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> tok.valid)
    else $error("intake stalled with an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(pop))
    else $error("result appeared without a parsed item");
`endif

endmodule

// File: tb/delimited_text_field_tokenizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delimited_text_field_tokenizer_test: self-checking bench of the tokenizer
// Streams comma and tab separated text, including malformed and random bytes,
// under random stalls on both channels. A scoreboard predicts every field
// result from each accepted byte and compares results in order.
// ----------------------------------------------------------------------------
module delimited_text_field_tokenizer_test;
  import dtft_pkg::*;

  localparam int          ItemTarget   = 2000;
  localparam int          SettleCycles = 12;
  localparam int          MaxReports   = 10;
  localparam int unsigned CycleLimit   = 2000000;

  typedef enum logic [2:0] {
    PhRowStart, PhLead, PhBare, PhQuoted, PhAfterQuote, PhError, PhTabField
  } phase_e;

  typedef struct packed {
    status_e                status;
    logic [FieldRowW-1:0]   row;
    logic [FieldColW-1:0]   col;
    logic [FieldOffW-1:0]   span_lo;
    logic [FieldOffW-1:0]   span_hi;
    logic                   row_end;
  } field_rec_t;

  class field_scoreboard;
    field_rec_t            fields[$];
    int                    failures;
    int                    reported;
    bit                    mode;
    bit                    active_mode;
    phase_e                phase;
    logic [OffsetBits-1:0] pos;
    logic [RowBits-1:0]    row_cnt;
    logic [ColBits-1:0]    col_cnt;
    logic [OffsetBits-1:0] c_start;
    logic [OffsetBits:0]   c_end;
    logic [OffsetBits-1:0] in_start;
    logic [OffsetBits:0]   in_end;
    logic [1:0]            qflags;
    bit                    lf_skip;
    int                    nonblank;

    function new();
      failures    = 0;
      reported    = 0;
      mode        = 1'b0;
      active_mode = 1'b0;
      restart();
    endfunction

    function void restart();
      phase    = PhRowStart;
      pos      = '0;
      row_cnt  = '0;
      col_cnt  = '0;
      c_start  = '0;
      c_end    = '0;
      in_start = '0;
      in_end   = '0;
      qflags   = '0;
      lf_skip  = 1'b0;
      nonblank = 0;
    endfunction

    function void set_mode(bit m);
      mode = m;
    endfunction

    function int outstanding();
      return fields.size();
    endfunction

    function void emit(status_e st, logic [OffsetBits-1:0] lo, logic [OffsetBits-1:0] hi,
                       bit row_end);
      field_rec_t r;
      r.status  = st;
      r.row     = row_cnt;
      r.col     = col_cnt;
      r.span_lo = lo;
      r.span_hi = hi;
      r.row_end = row_end;
      fields.push_back(r);
      if (st == StField) begin
        if (row_end) begin
          if (row_cnt != '1) row_cnt++;
          col_cnt = '0;
        end else if (col_cnt != '1) begin
          col_cnt++;
        end
      end
    endfunction

    function void emit_tab(logic [OffsetBits-1:0] p, bit row_end);
      if (nonblank == 0) begin
        emit(StField, p, p, row_end);
      end else if (nonblank >= 2 && qflags == 2'b11) begin
        emit(StField, in_start,
             (in_end > {1'b0, in_start}) ? in_end[OffsetBits-1:0] : in_start, row_end);
      end else begin
        emit(StField, c_start, c_end[OffsetBits-1:0], row_end);
      end
      nonblank = 0;
      qflags   = '0;
    endfunction

    function void end_line(logic [7:0] b);
      phase   = PhRowStart;
      lf_skip = (b == ChCr);
    endfunction

    function void note_byte(logic [7:0] b, bit eot);
      logic [OffsetBits-1:0] p;
      bit                    blank;
      bit                    line_brk;
      p = pos;
      if (eot || b == 8'd0) begin
        case (phase)
          PhLead:                 emit(StField, p, p, 1'b1);
          PhBare, PhAfterQuote:   emit(StField, c_start, c_end[OffsetBits-1:0], 1'b1);
          PhQuoted:               emit(StOpenQuote, p, p, 1'b0);
          PhTabField:             emit_tab(p, 1'b1);
          default: ;
        endcase
        restart();
        return;
      end
      if (pos != '1) pos++;
      if (phase == PhRowStart) begin
        if (lf_skip && b == ChLf) begin
          lf_skip = 1'b0;
          return;
        end
        lf_skip     = 1'b0;
        active_mode = mode;
        if (active_mode) begin
          phase    = PhTabField;
          nonblank = 0;
          qflags   = '0;
        end else begin
          phase = PhLead;
        end
      end
      blank    = (b == ChSp || b == ChTab);
      line_brk = (b == ChLf || b == ChCr);
      case (phase)
        PhLead: begin
          if (blank) begin
          end else if (b == ChQuote) begin
            phase    = PhQuoted;
            nonblank = 0;
          end else if (b == ChComma) begin
            emit(StField, p, p, 1'b0);
          end else if (line_brk) begin
            emit(StField, p, p, 1'b1);
            end_line(b);
          end else begin
            phase   = PhBare;
            c_start = p;
            c_end   = {1'b0, p} + 1'b1;
          end
        end
        PhBare: begin
          if (b == ChComma) begin
            emit(StField, c_start, c_end[OffsetBits-1:0], 1'b0);
            phase = PhLead;
          end else if (line_brk) begin
            emit(StField, c_start, c_end[OffsetBits-1:0], 1'b1);
            end_line(b);
          end else if (!blank) begin
            c_end = {1'b0, p} + 1'b1;
          end
        end
        PhQuoted: begin
          if (b == ChQuote) begin
            if (nonblank == 0) begin
              c_start = p;
              c_end   = {1'b0, p};
            end
            phase = PhAfterQuote;
          end else if (!blank) begin
            if (nonblank == 0) begin
              c_start  = p;
              nonblank = 1;
            end
            c_end = {1'b0, p} + 1'b1;
          end
        end
        PhAfterQuote: begin
          if (blank) begin
          end else if (b == ChComma) begin
            emit(StField, c_start, c_end[OffsetBits-1:0], 1'b0);
            phase = PhLead;
          end else if (line_brk) begin
            emit(StField, c_start, c_end[OffsetBits-1:0], 1'b1);
            end_line(b);
          end else begin
            emit(StBadChar, p, p, 1'b0);
            phase = PhError;
          end
        end
        PhTabField: begin
          if (b == ChTab) begin
            emit_tab(p, 1'b0);
          end else if (line_brk) begin
            emit_tab(p, 1'b1);
            end_line(b);
          end else if (b != ChSp) begin
            if (nonblank == 0) begin
              c_start = p;
              qflags  = {1'b0, (b == ChQuote)};
            end else begin
              if (nonblank == 1) in_start = p;
              in_end = c_end;
            end
            c_end = {1'b0, p} + 1'b1;
            if (nonblank < 2) nonblank++;
            qflags = {(b == ChQuote), qflags[0]};
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(field_rec_t got);
      field_rec_t exp_f;
      if (fields.size() == 0) begin
        failures++;
        if (reported < MaxReports) begin
          reported++;
          $display("unexpected field: st=%0d row=%0d col=%0d span=%0d..%0d end=%0d",
                   got.status, got.row, got.col, got.span_lo, got.span_hi, got.row_end);
        end
        return;
      end
      exp_f = fields.pop_front();
      if (got !== exp_f) begin
        failures++;
        if (reported < MaxReports) begin
          reported++;
          $display("field mismatch: expected st=%0d row=%0d col=%0d span=%0d..%0d end=%0d",
                   exp_f.status, exp_f.row, exp_f.col, exp_f.span_lo, exp_f.span_hi,
                   exp_f.row_end);
          $display("                actual   st=%0d row=%0d col=%0d span=%0d..%0d end=%0d",
                   got.status, got.row, got.col, got.span_lo, got.span_hi, got.row_end);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dtft_in_if  in_if();
  dtft_out_if out_if();
  dtft_cfg_if cfg_if();

  delimited_text_field_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  field_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          sent        = 0;
  int          hold_req    = 0;
  bit          calm_tx     = 1'b0;
  bit          calm_rx     = 1'b0;
  bit          cur_mode    = 1'b0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    field_rec_t got;
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (in_if.valid && in_if.ready) sb.note_byte(in_if.data_byte, in_if.end_of_text);
    if (cfg_if.valid && cfg_if.ready) sb.set_mode(cfg_if.format_mode);
    if (out_if.valid && out_if.ready) begin
      got.status  = status_e'(out_if.status);
      got.row     = out_if.row_index;
      got.col     = out_if.column_index;
      got.span_lo = out_if.field_start;
      got.span_hi = out_if.field_end;
      got.row_end = out_if.last_in_row;
      sb.check_field(got);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  initial begin
    int gap;
    out_if.ready = 1'b0;
    forever begin
      if (hold_req != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end else if (calm_rx) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_if.ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end else begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  task automatic push(input logic [7:0] b, input bit eot);
    int gap;
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.end_of_text <= eot;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
    gap = calm_tx ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push(s[i], 1'b0);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit m);
    cfg_if.valid       <= 1'b1;
    cfg_if.format_mode <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_mode = m;
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == ChTab || b == ChLf || b == ChCr || b == ChSp || b == ChQuote || b == ChComma);
    return b;
  endfunction

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) != 0) ? ChSp : ChTab;
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 7))
      0: return ChTab;
      1: return ChLf;
      2: return ChCr;
      3: return ChSp;
      4: return ChQuote;
      5: return ChComma;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic push_blanks(input bit tab_ok, input int max_n);
    repeat ($urandom_range(0, max_n)) push(tab_ok ? pick_blank() : ChSp, 1'b0);
  endtask

  task automatic push_line_end();
    case ($urandom_range(0, 2))
      0: push(ChCr, 1'b0);
      1: push(ChLf, 1'b0);
      default: begin
        push(ChCr, 1'b0);
        push(ChLf, 1'b0);
      end
    endcase
  endtask

  task automatic push_end_mark();
    if ($urandom_range(0, 9) < 7) push(8'($urandom_range(0, 255)), 1'b1);
    else push(8'd0, 1'b0);
  endtask

  task automatic push_quoted_body(input int max_n);
    int r;
    repeat ($urandom_range(0, max_n)) begin
      r = $urandom_range(0, 19);
      if (r < 12) push(pick_plain(), 1'b0);
      else if (r < 15) push(pick_blank(), 1'b0);
      else if (r < 17) push(ChComma, 1'b0);
      else push(($urandom_range(0, 1) != 0) ? ChCr : ChLf, 1'b0);
    end
  endtask

  task automatic send_csv_field();
    push_blanks(1'b1, 2);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        push(pick_plain(), 1'b0);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 5))
            0: push(pick_blank(), 1'b0);
            1: push(ChQuote, 1'b0);
            default: push(pick_plain(), 1'b0);
          endcase
        end
      end
      2: begin
        push(ChQuote, 1'b0);
        push_blanks(1'b1, 2);
        push_quoted_body(6);
        push_blanks(1'b1, 2);
        push(ChQuote, 1'b0);
      end
      default: begin
        push(ChQuote, 1'b0);
        push_blanks(1'b1, 3);
        push(ChQuote, 1'b0);
      end
    endcase
    push_blanks(1'b1, 2);
  endtask

  task automatic send_csv_rows(input int rows);
    int cols;
    for (int r = 0; r < rows; r++) begin
      cols = $urandom_range(1, 6);
      for (int c = 0; c < cols; c++) begin
        send_csv_field();
        if (c != cols - 1) push(ChComma, 1'b0);
      end
      if (r != rows - 1 || $urandom_range(0, 1) != 0) push_line_end();
    end
  endtask

  task automatic send_tab_field();
    push_blanks(1'b0, 2);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 4) == 0) push(ChSp, 1'b0);
          else if ($urandom_range(0, 9) == 0) push(ChQuote, 1'b0);
          else push(pick_plain(), 1'b0);
        end
      end
      2: begin
        push(ChQuote, 1'b0);
        push_blanks(1'b0, 2);
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 5) == 0) push(ChSp, 1'b0);
          else if ($urandom_range(0, 7) == 0) push(ChComma, 1'b0);
          else push(pick_plain(), 1'b0);
        end
        push_blanks(1'b0, 2);
        push(ChQuote, 1'b0);
      end
      default: push(ChQuote, 1'b0);
    endcase
    push_blanks(1'b0, 2);
  endtask

  task automatic send_tab_rows(input int rows);
    int cols;
    for (int r = 0; r < rows; r++) begin
      cols = $urandom_range(1, 6);
      for (int c = 0; c < cols; c++) begin
        send_tab_field();
        if (c != cols - 1) push(ChTab, 1'b0);
      end
      if (r != rows - 1 || $urandom_range(0, 1) != 0) push_line_end();
    end
  endtask

  task automatic send_broken_csv();
    send_csv_rows($urandom_range(0, 2));
    if ($urandom_range(0, 1) != 0) push_csv_field_partial();
    push(ChQuote, 1'b0);
    push_quoted_body(5);
    if ($urandom_range(0, 1) != 0) begin
      push(ChQuote, 1'b0);
      push_blanks(1'b1, 2);
      push(($urandom_range(0, 3) == 0) ? ChQuote : pick_plain(), 1'b0);
      repeat ($urandom_range(0, 6)) push(8'($urandom_range(1, 255)), 1'b0);
    end
    push_end_mark();
  endtask

  task automatic push_csv_field_partial();
    send_csv_field();
    push(ChComma, 1'b0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(5, 40)) begin
      if ($urandom_range(0, 29) == 0) push(8'd0, 1'b0);
      else push(pick_noise(), 1'b0);
    end
    push_end_mark();
  endtask

  initial begin
    int kind;
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.end_of_text    = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.format_mode   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    push(8'hFF, 1'b1);
    send_text("a,\"\",\r\n");
    push(ChSp, 1'b1);
    send_text("\"x\"y,z");
    push(8'd0, 1'b0);
    send_text(" \"\t");
    push(8'h41, 1'b1);
    wait_drain();
    write_mode(1'b1);
    send_text("\" q\"\t\377\n");
    push(8'h00, 1'b1);
    wait_drain();

    // saturate the column counter
    write_mode(1'b0);
    calm_tx = 1'b1;
    repeat (1030) push(ChComma, 1'b0);
    push(ChLf, 1'b0);
    push_end_mark();

    // hold the result side off while bytes keep coming
    hold_req = 300;
    repeat (60) push(ChComma, 1'b0);
    push_line_end();
    push_end_mark();
    calm_tx = 1'b0;
    wait_drain();

    while (sent < ItemTarget) begin
      calm_tx = ($urandom_range(0, 4) == 0);
      calm_rx = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        wait_drain();
        write_mode(1'($urandom_range(0, 1)));
      end
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        if (cur_mode) send_tab_rows($urandom_range(1, 6));
        else send_csv_rows($urandom_range(1, 6));
        push_end_mark();
      end else if (kind == 8 && !cur_mode) begin
        send_broken_csv();
      end else begin
        send_noise();
      end
    end
    calm_rx = 1'b0;
    wait_drain();

    if (sb.outstanding() != 0) sb.failures += sb.outstanding();
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dtft_pkg.sv
hw/rtl/dtft_if.sv
hw/rtl/dtft_front.sv
hw/rtl/dtft_back.sv
hw/rtl/delimited_text_field_tokenizer.sv
tb/delimited_text_field_tokenizer_test.sv
